// ----- design/lbp_pkg.sv -----
// Shared constants for the longest border prefix block.
package lbp_pkg;

   localparam int MAX_LEN_DEF = 64;
   localparam int CHAR_W      = 8;
   localparam int LEN_W       = 6;
   localparam int MAX_RESULTS = 63;

endpackage

// ----- design/longest_border_prefix.sv -----
// Top level of the longest border prefix block.
//
// Usage: drive req_char_in and req_end_of_string with start high; the
// request is taken at a rising edge where busy is low. Set req_end_of_string
// on the final byte of a string. Bytes arriving once MAX_LEN are stored are
// dropped and flagged with rsp_overflowed on every result of the run.
// A byte walks the fallback links through the border table, one step per
// candidate tried (the first byte of a string and a dropped byte take none);
// each step is one read of the text and border memories.
// After the final byte's fallback steps, ST_FINISH, ST_EMIT and the result
// register, the results follow one per cycle: the border bytes in order,
// with rsp_last_of_run on the last. An empty border gives a single result
// with rsp_empty_border high. Results are one-cycle strobes on rsp_valid;
// the receiver cannot stall them. After the run the string state is cleared.
// Reset clears control state only; the memories need no clearing pass.
module longest_border_prefix #(
   parameter int MAX_LEN = lbp_pkg::MAX_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [lbp_pkg::CHAR_W-1:0] req_char_in,
   input  logic                       req_end_of_string,
   output logic                       rsp_valid,
   output logic [lbp_pkg::CHAR_W-1:0] rsp_char_out,
   output logic [lbp_pkg::LEN_W-1:0]  rsp_border_length,
   output logic                       rsp_empty_border,
   output logic                       rsp_overflowed,
   output logic                       rsp_last_of_run
);

   localparam int AW = $clog2(MAX_LEN);

   logic                       text_wr_en;
   logic [AW-1:0]              text_wr_addr;
   logic [lbp_pkg::CHAR_W-1:0] text_wr_data;
   logic [AW-1:0]              text_rd_addr;
   logic [lbp_pkg::CHAR_W-1:0] text_rd_data;
   logic                       border_wr_en;
   logic [AW-1:0]              border_wr_addr;
   logic [AW-1:0]              border_wr_data;
   logic [AW-1:0]              border_rd_addr;
   logic [AW-1:0]              border_rd_data;

   lbp_ram #(
      .WIDTH (lbp_pkg::CHAR_W),
      .DEPTH (MAX_LEN)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (text_wr_en),
      .wr_addr (text_wr_addr),
      .wr_data (text_wr_data),
      .rd_addr (text_rd_addr),
      .rd_data (text_rd_data)
   );

   lbp_ram #(
      .WIDTH (AW),
      .DEPTH (MAX_LEN)
   ) u_border_ram (
      .clock   (clock),
      .wr_en   (border_wr_en),
      .wr_addr (border_wr_addr),
      .wr_data (border_wr_data),
      .rd_addr (border_rd_addr),
      .rd_data (border_rd_data)
   );

   lbp_core #(
      .MAX_LEN (MAX_LEN)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_char_in       (req_char_in),
      .req_end_of_string (req_end_of_string),
      .text_wr_en        (text_wr_en),
      .text_wr_addr      (text_wr_addr),
      .text_wr_data      (text_wr_data),
      .text_rd_addr      (text_rd_addr),
      .text_rd_data      (text_rd_data),
      .border_wr_en      (border_wr_en),
      .border_wr_addr    (border_wr_addr),
      .border_wr_data    (border_wr_data),
      .border_rd_addr    (border_rd_addr),
      .border_rd_data    (border_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_char_out      (rsp_char_out),
      .rsp_border_length (rsp_border_length),
      .rsp_empty_border  (rsp_empty_border),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ----- design/lbp_ram.sv -----
// Generic RAM with one write port and one registered read port.
module lbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lbp_core.sv -----
// Sequencer: online border-table update by fallback links and border emission.
module lbp_core #(
   parameter int MAX_LEN = lbp_pkg::MAX_LEN_DEF,
   localparam int AW     = $clog2(MAX_LEN),
   localparam int CW     = $clog2(MAX_LEN + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [lbp_pkg::CHAR_W-1:0] req_char_in,
   input  logic                       req_end_of_string,
   output logic                       text_wr_en,
   output logic [AW-1:0]              text_wr_addr,
   output logic [lbp_pkg::CHAR_W-1:0] text_wr_data,
   output logic [AW-1:0]              text_rd_addr,
   input  logic [lbp_pkg::CHAR_W-1:0] text_rd_data,
   output logic                       border_wr_en,
   output logic [AW-1:0]              border_wr_addr,
   output logic [AW-1:0]              border_wr_data,
   output logic [AW-1:0]              border_rd_addr,
   input  logic [AW-1:0]              border_rd_data,
   output logic                       rsp_valid,
   output logic [lbp_pkg::CHAR_W-1:0] rsp_char_out,
   output logic [lbp_pkg::LEN_W-1:0]  rsp_border_length,
   output logic                       rsp_empty_border,
   output logic                       rsp_overflowed,
   output logic                       rsp_last_of_run
);

   localparam int WW = AW + lbp_pkg::LEN_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MATCH  = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [AW-1:0]              cm_ff, cm_in;
   logic                       ovf_ff, ovf_in;
   logic [lbp_pkg::CHAR_W-1:0] ch_ff, ch_in;
   logic                       last_ff, last_in;
   logic [AW-1:0]              m_ff, m_in;
   logic [lbp_pkg::LEN_W-1:0]  k_ff, k_in;
   logic [lbp_pkg::LEN_W-1:0]  emit_ff, emit_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_empty_ff, rsp_empty_in;
   logic [lbp_pkg::LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   logic                       hit;
   logic                       step_done;
   logic [AW-1:0]              match_len;
   logic [WW-1:0]              cm_wide;
   logic [lbp_pkg::LEN_W-1:0]  emit_len;
   logic                       full;
   logic                       emit_last;

   assign hit       = (text_rd_data == ch_ff);
   assign step_done = hit || (m_ff == '0);
   assign match_len = hit ? (m_ff + AW'(1)) : '0;
   assign cm_wide   = WW'(cm_ff);
   assign emit_len  = (cm_wide > WW'(lbp_pkg::MAX_RESULTS)) ?
                      lbp_pkg::LEN_W'(lbp_pkg::MAX_RESULTS) : cm_wide[lbp_pkg::LEN_W-1:0];
   assign full      = (count_ff == CW'(MAX_LEN));
   assign emit_last = (k_ff == (emit_ff - lbp_pkg::LEN_W'(1)));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cm_in          = cm_ff;
      ovf_in         = ovf_ff;
      ch_in          = ch_ff;
      last_in        = last_ff;
      m_in           = m_ff;
      k_in           = k_ff;
      emit_in        = emit_ff;
      rsp_valid_in   = 1'b0;
      rsp_last_in    = rsp_last_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      text_wr_en     = 1'b0;
      text_wr_addr   = count_ff[AW-1:0];
      text_wr_data   = req_char_in;
      text_rd_addr   = cm_ff;
      border_wr_en   = 1'b0;
      border_wr_addr = count_ff[AW-1:0];
      border_wr_data = match_len;
      border_rd_addr = cm_ff - AW'(1);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (full) begin
                  ovf_in = 1'b1;
                  if (req_end_of_string) begin
                     state_in = ST_FINISH;
                  end
               end else if (count_ff == '0) begin
                  text_wr_en     = 1'b1;
                  border_wr_en   = 1'b1;
                  border_wr_data = '0;
                  cm_in          = '0;
                  count_in       = CW'(1);
                  if (req_end_of_string) begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  text_wr_en = 1'b1;
                  m_in       = cm_ff;
                  ch_in      = req_char_in;
                  last_in    = req_end_of_string;
                  state_in   = ST_MATCH;
               end
            end
         end
         ST_MATCH: begin
            text_rd_addr   = border_rd_data;
            border_rd_addr = border_rd_data - AW'(1);
            if (step_done) begin
               border_wr_en = 1'b1;
               cm_in        = match_len;
               count_in     = count_ff + CW'(1);
               state_in     = last_ff ? ST_FINISH : ST_IDLE;
            end else begin
               m_in = border_rd_data;
            end
         end
         ST_FINISH: begin
            rsp_len_in = emit_len;
            rsp_ovf_in = ovf_ff;
            if (emit_len == '0) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = 1'b1;
               rsp_last_in  = 1'b1;
               count_in     = '0;
               cm_in        = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               emit_in  = emit_len;
               k_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            text_rd_addr = AW'(k_ff);
            rsp_valid_in = 1'b1;
            rsp_empty_in = 1'b0;
            rsp_last_in  = emit_last;
            k_in         = k_ff + lbp_pkg::LEN_W'(1);
            if (emit_last) begin
               count_in = '0;
               cm_in    = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cm_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cm_ff        <= cm_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      last_ff      <= last_in;
      m_ff         <= m_in;
      k_ff         <= k_in;
      emit_ff      <= emit_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_out      = rsp_empty_ff ? '0 : text_rd_data;
   assign rsp_border_length = rsp_len_ff;
   assign rsp_empty_border  = rsp_empty_ff;
   assign rsp_overflowed    = rsp_ovf_ff;
   assign rsp_last_of_run   = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LEN))
      else $error("byte count above capacity");

   a_match_below_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (CW'(cm_ff) < count_ff))
      else $error("current match not below byte count");

   a_fallback_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH) |-> (m_ff <= cm_ff))
      else $error("fallback candidate above current match");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> rsp_last_ff)
      else $error("empty border result not last of run");

   a_cleared_after_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> ((count_ff == '0) && (cm_ff == '0) && !ovf_ff))
      else $error("string state not cleared after run");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for longest_border_prefix: directed strings, then random streams.
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      logic [lbp_pkg::CHAR_W-1:0] ch;
      logic [lbp_pkg::LEN_W-1:0]  len;
      logic                       empty;
      logic                       ovf;
      logic                       last;
   } border_byte_type;

   typedef struct packed {
      logic [lbp_pkg::CHAR_W-1:0] ch;
      logic                       eos;
      logic                       typed;
      border_byte_type            want;
   } dir_row_type;

   localparam border_byte_type NO_RESULT = '0;
   localparam int N_DIR = 22;
   localparam int N_RANDOM = 400;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [lbp_pkg::CHAR_W-1:0] req_char_in;
   logic                       req_end_of_string;
   logic                       rsp_valid;
   logic [lbp_pkg::CHAR_W-1:0] rsp_char_out;
   logic [lbp_pkg::LEN_W-1:0]  rsp_border_length;
   logic                       rsp_empty_border;
   logic                       rsp_overflowed;
   logic                       rsp_last_of_run;

   logic [lbp_pkg::CHAR_W-1:0] text_mem [0:lbp_pkg::MAX_LEN_DEF-1];
   int                         border_mem [0:lbp_pkg::MAX_LEN_DEF-1];
   int                         cur_match;
   int                         seen_count;
   bit                         seen_ovf;

   border_byte_type fresh_run [$];
   border_byte_type pending_border [$];
   dir_row_type     dir_rows [N_DIR];

   int errors;
   int n_requests;
   int n_strings;
   int n_results;
   int n_ovf_runs;
   int n_empty_runs;
   int max_border;

   longest_border_prefix dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_char_in       (req_char_in),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_char_out      (rsp_char_out),
      .rsp_border_length (rsp_border_length),
      .rsp_empty_border  (rsp_empty_border),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   // Add a byte to the border table if room; on the final byte, build the run of results.
   task automatic absorb_byte(input logic [lbp_pkg::CHAR_W-1:0] c, input bit eos);
      int m;
      int brd;
      int n;
      border_byte_type r;
      fresh_run.delete();
      if (seen_count >= lbp_pkg::MAX_LEN_DEF) begin
         seen_ovf = 1'b1;
      end else begin
         text_mem[seen_count] = c;
         if (seen_count == 0) begin
            m = 0;
         end else begin
            m = cur_match;
            while (m > 0 && text_mem[m] != c)
               m = border_mem[m-1];
            if (text_mem[m] == c)
               m++;
         end
         border_mem[seen_count] = m;
         cur_match = m;
         seen_count++;
      end
      if (eos) begin
         brd = (seen_count > 0) ? border_mem[seen_count-1] : 0;
         n = (brd > lbp_pkg::MAX_RESULTS) ? lbp_pkg::MAX_RESULTS : brd;
         if (n == 0) begin
            r = '{ch: '0, len: '0, empty: 1'b1, ovf: seen_ovf, last: 1'b1};
            fresh_run.push_back(r);
         end else begin
            for (int k = 0; k < n; k++) begin
               r = '{ch: text_mem[k], len: lbp_pkg::LEN_W'(n), empty: 1'b0, ovf: seen_ovf,
                     last: (k == n - 1)};
               fresh_run.push_back(r);
            end
         end
         seen_count = 0;
         cur_match = 0;
         seen_ovf = 1'b0;
      end
   endtask

   // Present one request, hold it until taken, then queue its results.
   task automatic send_byte(input logic [lbp_pkg::CHAR_W-1:0] c, input bit eos,
                            input bit quiet, input bit typed,
                            input border_byte_type typed_want);
      int gap;
      if (!quiet && $urandom_range(99) < 33) begin
         start = 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_char_in = c;
      req_end_of_string = eos;
      do @(posedge clock); while (busy);
      n_requests++;
      absorb_byte(c, eos);
      if (eos) begin
         n_strings++;
         if (fresh_run[0].ovf) n_ovf_runs++;
         if (fresh_run[0].empty) n_empty_runs++;
         if (int'(fresh_run[0].len) > max_border) max_border = int'(fresh_run[0].len);
      end
      if (typed)
         pending_border.push_back(typed_want);
      else
         foreach (fresh_run[i]) pending_border.push_back(fresh_run[i]);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      border_byte_type want;
      if (!reset && rsp_valid) begin
         if (pending_border.size() == 0) begin
            $error("unexpected result: char_out=%h border_length=%0d empty_border=%b",
                   rsp_char_out, rsp_border_length, rsp_empty_border);
            errors++;
         end else begin
            want = pending_border.pop_front();
            n_results++;
            if (rsp_char_out !== want.ch) begin
               $error("char_out: expected %h, got %h", want.ch, rsp_char_out);
               errors++;
            end
            if (rsp_border_length !== want.len) begin
               $error("border_length: expected %0d, got %0d", want.len, rsp_border_length);
               errors++;
            end
            if (rsp_empty_border !== want.empty) begin
               $error("empty_border: expected %b, got %b", want.empty, rsp_empty_border);
               errors++;
            end
            if (rsp_overflowed !== want.ovf) begin
               $error("overflowed: expected %b, got %b", want.ovf, rsp_overflowed);
               errors++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %b, got %b", want.last, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   initial begin
      int len;
      int sel;
      int period;
      bit quiet;
      logic [lbp_pkg::CHAR_W-1:0] base;
      logic [lbp_pkg::CHAR_W-1:0] c;
      logic [lbp_pkg::CHAR_W-1:0] pat [0:4];

      reset = 1'b1;
      start = 1'b0;
      req_char_in = '0;
      req_end_of_string = 1'b0;
      errors = 0;
      n_requests = 0;
      n_strings = 0;
      n_results = 0;
      n_ovf_runs = 0;
      n_empty_runs = 0;
      max_border = 0;
      seen_count = 0;
      cur_match = 0;
      seen_ovf = 1'b0;

      dir_rows = '{
         '{8'h00, 1'b1, 1'b1, '{8'h00, 6'd0, 1'b1, 1'b0, 1'b1}},
         '{8'hFF, 1'b1, 1'b1, '{8'h00, 6'd0, 1'b1, 1'b0, 1'b1}},
         '{8'h61, 1'b0, 1'b0, NO_RESULT},
         '{8'h61, 1'b1, 1'b1, '{8'h61, 6'd1, 1'b0, 1'b0, 1'b1}},
         '{8'h61, 1'b0, 1'b0, NO_RESULT},
         '{8'h62, 1'b1, 1'b1, '{8'h00, 6'd0, 1'b1, 1'b0, 1'b1}},
         '{8'h61, 1'b0, 1'b0, NO_RESULT},
         '{8'h62, 1'b0, 1'b0, NO_RESULT},
         '{8'h61, 1'b0, 1'b0, NO_RESULT},
         '{8'h62, 1'b1, 1'b0, NO_RESULT},
         '{8'h61, 1'b0, 1'b0, NO_RESULT},
         '{8'h61, 1'b0, 1'b0, NO_RESULT},
         '{8'h62, 1'b0, 1'b0, NO_RESULT},
         '{8'h61, 1'b0, 1'b0, NO_RESULT},
         '{8'h61, 1'b0, 1'b0, NO_RESULT},
         '{8'h61, 1'b0, 1'b0, NO_RESULT},
         '{8'h62, 1'b1, 1'b0, NO_RESULT},
         '{8'h80, 1'b0, 1'b0, NO_RESULT},
         '{8'h80, 1'b0, 1'b0, NO_RESULT},
         '{8'h7F, 1'b0, 1'b0, NO_RESULT},
         '{8'h80, 1'b0, 1'b0, NO_RESULT},
         '{8'h80, 1'b1, 1'b0, NO_RESULT}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_byte(dir_rows[i].ch, dir_rows[i].eos, 1'b0, dir_rows[i].typed,
                   dir_rows[i].want);

      // Fill the store exactly with one byte value: longest possible border.
      c = lbp_pkg::CHAR_W'($urandom_range(255));
      for (int i = 0; i < lbp_pkg::MAX_LEN_DEF; i++)
         send_byte(c, i == lbp_pkg::MAX_LEN_DEF - 1, 1'b0, 1'b0, NO_RESULT);
      // Overrun the store, with the final byte itself dropped.
      c = lbp_pkg::CHAR_W'($urandom_range(255));
      for (int i = 0; i < lbp_pkg::MAX_LEN_DEF + 3; i++)
         send_byte(c ^ lbp_pkg::CHAR_W'(i % 2), i == lbp_pkg::MAX_LEN_DEF + 2, 1'b0, 1'b0,
                   NO_RESULT);

      while (n_requests < N_DIR + N_RANDOM) begin
         quiet = (n_requests >= 250 && n_requests < 350);
         sel = $urandom_range(99);
         if (sel < 5)
            len = $urandom_range(60, 70);
         else if (sel < 45)
            len = $urandom_range(1, 12);
         else
            len = $urandom_range(2, 24);
         period = $urandom_range(1, 5);
         base = lbp_pkg::CHAR_W'($urandom_range(255));
         for (int k = 0; k < 5; k++) pat[k] = lbp_pkg::CHAR_W'($urandom_range(255));
         for (int i = 0; i < len; i++) begin
            if (sel >= 5 && sel < 45)
               c = base + lbp_pkg::CHAR_W'($urandom_range(1));
            else if ($urandom_range(99) < 10)
               c = lbp_pkg::CHAR_W'($urandom_range(255));
            else
               c = pat[i % period];
            send_byte(c, i == len - 1, quiet, 1'b0, NO_RESULT);
         end
      end
      start = 1'b0;

      while (pending_border.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("tb: %0d requests in %0d strings, %0d results checked", n_requests, n_strings,
               n_results);
      $display("tb: %0d empty borders, %0d overflowed strings, longest border %0d",
               n_empty_runs, n_ovf_runs, max_border);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
